// ===== rtl/core/osi_pkg.sv =====
// Shared types, codes and reset values for the obstacle stop interlock.
`timescale 1ns / 1ps
`default_nettype none

package osi_pkg;

    localparam int CODE_W    = 8;
    localparam int OPCODE_W  = 3;
    localparam int TONE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_HEALTH   = 3'd0,
        OP_PACKET   = 3'd1,
        OP_PRIMARY  = 3'd2,
        OP_STATUS3D = 3'd3,
        OP_SECOND   = 3'd4,
        OP_WAYPOINT = 3'd5
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_END_ZONE    = 3'd0,
        REG_SECOND_STOP = 3'd1,
        REG_OBJECT_A    = 3'd2,
        REG_OBJECT_B    = 3'd3,
        REG_OBJECT_3D   = 3'd4
    } t_reg_idx;

    localparam logic [TONE_W-1:0] TONE_NONE = 2'd0;
    localparam logic [TONE_W-1:0] TONE_ON   = 2'd1;
    localparam logic [TONE_W-1:0] TONE_OFF  = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] end_zone_code;
        logic [CODE_W-1:0] second_stop_code;
        logic [CODE_W-1:0] object_code_a;
        logic [CODE_W-1:0] object_code_b;
        logic [CODE_W-1:0] object_3d_code;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        end_zone_code:    8'd2,
        second_stop_code: 8'd3,
        object_code_a:    8'd4,
        object_code_b:    8'd5,
        object_3d_code:   8'd1
    };

    typedef struct packed {
        logic              second_stop_armed;
        logic              stopped;
        logic              in_zone;
        logic              at_stop_point;
        logic              detector_healthy;
        logic              primary_seen;
        logic              scan2d_seen;
        logic              scan3d_seen;
        logic              zone_lock;
        logic              notice_shown;
        logic [CODE_W-1:0] last_drive_mode;
    } t_state;

    localparam t_state STATE_RESET = '{
        second_stop_armed: 1'b0,
        stopped:           1'b0,
        in_zone:           1'b0,
        at_stop_point:     1'b0,
        detector_healthy:  1'b1,
        primary_seen:      1'b1,
        scan2d_seen:       1'b0,
        scan3d_seen:       1'b0,
        zone_lock:         1'b0,
        notice_shown:      1'b0,
        last_drive_mode:   8'd0
    };

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                flag_value;
        logic [CODE_W-1:0]   drive_mode;
        logic [CODE_W-1:0]   pot_code;
        logic [CODE_W-1:0]   status_code;
        logic [CODE_W-1:0]   zone_flag;
    } t_item;

    typedef struct packed {
        logic              stop_cmd;
        logic              start_cmd;
        logic              tone_valid;
        logic [TONE_W-1:0] tone_code;
        logic              error_notice;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/osi_eval.sv =====
// Next-state and result logic for one event of the obstacle stop interlock.
`timescale 1ns / 1ps
`default_nettype none

module osi_eval (
    input  wire osi_pkg::t_state  i_state,
    input  wire osi_pkg::t_cfg    i_cfg,
    input  wire osi_pkg::t_item   i_item,
    output osi_pkg::t_state       o_state,
    output osi_pkg::t_result      o_result
);

    osi_pkg::t_state  s;
    osi_pkg::t_result r;

    always_comb begin
        s = i_state;
        r = '0;
        case (i_item.opcode)
            osi_pkg::OP_HEALTH: begin
                s.detector_healthy = i_item.flag_value;
            end
            osi_pkg::OP_PACKET: begin
                if (i_item.drive_mode != i_state.last_drive_mode) begin
                    // mode change: return all flags to their reset values, silence the tone
                    s                 = osi_pkg::STATE_RESET;
                    s.last_drive_mode = i_item.drive_mode;
                    r.tone_valid      = 1'b1;
                    r.tone_code       = osi_pkg::TONE_OFF;
                end
                s.scan2d_seen = (i_item.pot_code == i_cfg.object_code_a) ||
                                (i_item.pot_code == i_cfg.object_code_b);
            end
            osi_pkg::OP_PRIMARY: begin
                s.primary_seen = i_item.flag_value;
            end
            osi_pkg::OP_STATUS3D: begin
                s.scan3d_seen = (i_item.status_code == i_cfg.object_3d_code);
            end
            osi_pkg::OP_SECOND: begin
                s.second_stop_armed = 1'b1;
            end
            osi_pkg::OP_WAYPOINT: begin
                // zone, lock and second-stop rules
                if (i_item.zone_flag == i_cfg.end_zone_code) begin
                    s.in_zone      = 1'b0;
                    s.zone_lock    = 1'b0;
                    s.primary_seen = 1'b1;
                end else if (!s.zone_lock && (i_item.zone_flag != '0) &&
                             (i_item.zone_flag != i_cfg.second_stop_code)) begin
                    s.at_stop_point = 1'b1;
                    s.zone_lock     = 1'b1;
                    s.in_zone       = 1'b1;
                end else if (s.zone_lock && s.second_stop_armed &&
                             (i_item.zone_flag == i_cfg.second_stop_code)) begin
                    s.at_stop_point     = 1'b1;
                    s.second_stop_armed = 1'b0;
                    s.primary_seen      = 1'b1;
                    s.zone_lock         = 1'b0;
                end else if (s.scan2d_seen || s.scan3d_seen) begin
                    if (s.in_zone && !s.at_stop_point) begin
                        s.primary_seen  = 1'b1;
                        s.at_stop_point = 1'b1;
                    end
                end

                // stop/start decision on the updated flags
                r.tone_valid = 1'b1;
                r.tone_code  = osi_pkg::TONE_NONE;
                if (s.at_stop_point) begin
                    if (s.detector_healthy) begin
                        s.notice_shown = 1'b0;
                        if (s.in_zone &&
                            (s.scan2d_seen || s.scan3d_seen || s.primary_seen)) begin
                            if (!s.stopped) begin
                                r.stop_cmd  = 1'b1;
                                s.stopped   = 1'b1;
                                r.tone_code = osi_pkg::TONE_ON;
                            end
                        end else begin
                            s.at_stop_point = 1'b0;
                            s.stopped       = 1'b0;
                            r.start_cmd     = 1'b1;
                            r.tone_code     = osi_pkg::TONE_OFF;
                        end
                    end else begin
                        r.tone_code = osi_pkg::TONE_OFF;
                        r.stop_cmd  = 1'b1;
                        if (!s.notice_shown) begin
                            r.error_notice = 1'b1;
                            s.notice_shown = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_state  = s;
    assign o_result = r;

endmodule

`default_nettype wire

// ===== rtl/core/obstacle_stop_interlock_top.sv =====
// An accepted beat goes input register -> event logic -> result register -> master side.
// Throughput: one beat per cycle while no result waits on i_m_tready downstream.
// Each event reads and updates the interlock flags in the same cycle it leaves the
// input register, so back-to-back beats see each other's effects in order.
// Reset (synchronous, active low): flags and config return to defaults, both stages empty.
// Top level of the obstacle stop interlock.
`timescale 1ns / 1ps
`default_nettype none

module obstacle_stop_interlock_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // event stream in
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // [0] flag_value, [8:1] drive_mode, [16:9] pot_code, [24:17] status_code,
    // [32:25] zone_flag, [39:33] zero
    input  wire  [osi_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // [2:0] opcode
    input  wire  [osi_pkg::IN_USER_W-1:0]       i_s_tuser,
    // result stream out
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // [0] stop_cmd, [1] start_cmd, [2] tone_valid, [4:3] tone_code,
    // [5] error_notice, [7:6] zero
    output logic [osi_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // configuration write port
    input  wire                                 i_cfg_we,
    input  wire  [osi_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [osi_pkg::CODE_W-1:0]          i_cfg_wdata
);

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce this.
    osi_pkg::t_cfg r_cfg;
    osi_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                osi_pkg::REG_END_ZONE:    n_cfg.end_zone_code    = i_cfg_wdata;
                osi_pkg::REG_SECOND_STOP: n_cfg.second_stop_code = i_cfg_wdata;
                osi_pkg::REG_OBJECT_A:    n_cfg.object_code_a    = i_cfg_wdata;
                osi_pkg::REG_OBJECT_B:    n_cfg.object_code_b    = i_cfg_wdata;
                osi_pkg::REG_OBJECT_3D:   n_cfg.object_3d_code   = i_cfg_wdata;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= osi_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Pipeline control: the whole pipe advances unless a result waits downstream.
    logic w_advance;
    logic w_in_take;

    logic            r_in_valid;
    osi_pkg::t_item  r_in_item;
    logic            r_out_valid;
    osi_pkg::t_result r_out_result;
    osi_pkg::t_state r_state;

    osi_pkg::t_state  w_state_next;
    osi_pkg::t_result w_result;
    osi_pkg::t_item   w_beat;

    assign w_advance  = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_in_take  = i_s_tvalid && o_s_tready;

    // Unpack the slave-side beat.
    assign w_beat.opcode      = i_s_tuser[2:0];
    assign w_beat.flag_value  = i_s_tdata[0];
    assign w_beat.drive_mode  = i_s_tdata[8:1];
    assign w_beat.pot_code    = i_s_tdata[16:9];
    assign w_beat.status_code = i_s_tdata[24:17];
    assign w_beat.zone_flag   = i_s_tdata[32:25];

    // Input register: hold the beat until the result stage can take it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= w_beat;
        end
    end

    osi_eval u_eval (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_item),
        .o_state  (w_state_next),
        .o_result (w_result)
    );

    // Commit the flag update only when the event moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= osi_pkg::STATE_RESET;
        end else if (r_in_valid && w_advance) begin
            r_state <= w_state_next;
        end
    end

    // Result register: a finished beat waits here until taken; an empty input register can still fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out_result <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00,
                         r_out_result.error_notice,
                         r_out_result.tone_code,
                         r_out_result.tone_valid,
                         r_out_result.start_cmd,
                         r_out_result.stop_cmd};

`ifndef SYNTHESIS
    // A single event never commands both stop and start.
    a_stop_start_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_result.stop_cmd && r_out_result.start_cmd))
        else $error("stop and start issued together");

    // The error notice only comes with a stop and the tone off.
    a_notice_with_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_result.error_notice) |->
            (r_out_result.stop_cmd && (r_out_result.tone_code == osi_pkg::TONE_OFF)))
        else $error("error notice without stop and tone off");

    // A stalled event must not touch the interlock flags.
    a_state_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> $stable(r_state))
        else $error("flags changed while the event was stalled");

    // Every waypoint result carries a published tone.
    a_waypoint_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_advance && (r_in_item.opcode == osi_pkg::OP_WAYPOINT)) |=>
            (r_out_valid && r_out_result.tone_valid))
        else $error("waypoint result without tone");
`endif

endmodule

`default_nettype wire

// ===== tb/obstacle_stop_interlock_checker.sv =====
// Scoreboard for the obstacle stop interlock: tracks the interlock flags and checks result beats.
`timescale 1ns / 1ps

module obstacle_stop_interlock_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    input  wire                              i_s_tready,
    // [0] flag_value, [8:1] drive_mode, [16:9] pot_code, [24:17] status_code,
    // [32:25] zone_flag, [39:33] zero
    input  wire  [osi_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [2:0] opcode
    input  wire  [osi_pkg::IN_USER_W-1:0]    i_s_tuser,
    input  wire                              i_m_tvalid,
    input  wire                              i_m_tready,
    // [0] stop_cmd, [1] start_cmd, [2] tone_valid, [4:3] tone_code,
    // [5] error_notice, [7:6] zero
    input  wire  [osi_pkg::OUT_DATA_W-1:0]   i_m_tdata,
    input  wire                              i_cfg_we,
    input  wire  [osi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [osi_pkg::CODE_W-1:0]       i_cfg_wdata,
    output int                               o_fail_count,
    output int                               o_pending
);

    osi_pkg::t_cfg    codes;
    osi_pkg::t_result verdicts_due[$];

    logic       armed2;
    logic       halted;
    logic       zone_active;
    logic       stop_pt;
    logic       det_ok;
    logic       prim_obj;
    logic       obj2d;
    logic       obj3d;
    logic       zone_locked;
    logic       notice_done;
    logic [7:0] mode_last;

    function automatic void clear_interlock();
        armed2      = 1'b0;
        halted      = 1'b0;
        zone_active = 1'b0;
        stop_pt     = 1'b0;
        det_ok      = 1'b1;
        prim_obj    = 1'b1;
        obj2d       = 1'b0;
        obj3d       = 1'b0;
        zone_locked = 1'b0;
        notice_done = 1'b0;
    endfunction

    // Zone entry/exit, zone lock and second-stop rules of a waypoint beat.
    function automatic void track_zone(input logic [7:0] zf);
        if (zf == codes.end_zone_code) begin
            zone_active = 1'b0;
            zone_locked = 1'b0;
            prim_obj    = 1'b1;
        end else if (!zone_locked && zf != 8'd0 && zf != codes.second_stop_code) begin
            stop_pt     = 1'b1;
            zone_locked = 1'b1;
            zone_active = 1'b1;
        end else if (zone_locked && zf == codes.second_stop_code && armed2) begin
            stop_pt     = 1'b1;
            armed2      = 1'b0;
            prim_obj    = 1'b1;
            zone_locked = 1'b0;
        end else if (obj2d || obj3d) begin
            if (zone_active && !stop_pt) begin
                prim_obj = 1'b1;
                stop_pt  = 1'b1;
            end
        end
    endfunction

    // Stop/start decision taken on every waypoint beat.
    function automatic osi_pkg::t_result stop_start_decision();
        osi_pkg::t_result res;
        logic [osi_pkg::TONE_W-1:0] tone;
        res  = '0;
        tone = osi_pkg::TONE_NONE;
        if (stop_pt) begin
            if (det_ok) begin
                notice_done = 1'b0;
                if (zone_active && (obj2d || obj3d || prim_obj)) begin
                    if (!halted) begin
                        res.stop_cmd = 1'b1;
                        halted       = 1'b1;
                        tone         = osi_pkg::TONE_ON;
                    end
                end else begin
                    stop_pt       = 1'b0;
                    halted        = 1'b0;
                    res.start_cmd = 1'b1;
                    tone          = osi_pkg::TONE_OFF;
                end
            end else begin
                tone         = osi_pkg::TONE_OFF;
                res.stop_cmd = 1'b1;
                if (!notice_done) begin
                    res.error_notice = 1'b1;
                    notice_done      = 1'b1;
                end
            end
        end
        res.tone_valid = 1'b1;
        res.tone_code  = tone;
        return res;
    endfunction

    function automatic osi_pkg::t_result interlock_event(
        input logic [osi_pkg::OPCODE_W-1:0] op,
        input logic [osi_pkg::IN_DATA_W-1:0] data
    );
        osi_pkg::t_result res;
        logic       flag;
        logic [7:0] mode;
        logic [7:0] pot;
        logic [7:0] status;
        logic [7:0] zf;
        flag   = data[0];
        mode   = data[8:1];
        pot    = data[16:9];
        status = data[24:17];
        zf     = data[32:25];
        res    = '0;
        case (op)
            osi_pkg::OP_HEALTH: det_ok = flag;
            osi_pkg::OP_PACKET: begin
                if (mode != mode_last) begin
                    clear_interlock();
                    mode_last      = mode;
                    res.tone_valid = 1'b1;
                    res.tone_code  = osi_pkg::TONE_OFF;
                end
                obj2d = (pot == codes.object_code_a) || (pot == codes.object_code_b);
            end
            osi_pkg::OP_PRIMARY:  prim_obj = flag;
            osi_pkg::OP_STATUS3D: obj3d = (status == codes.object_3d_code);
            osi_pkg::OP_SECOND:   armed2 = 1'b1;
            osi_pkg::OP_WAYPOINT: begin
                track_zone(zf);
                res = stop_start_decision();
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        osi_pkg::t_result want;
        if (!i_rst_n) begin
            codes     = osi_pkg::CFG_RESET;
            clear_interlock();
            mode_last = 8'd0;
            verdicts_due.delete();
            o_fail_count = 0;
        end else begin
            // Pop before push: a result beat never belongs to a beat accepted at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result beat 0x%02h with no expected result", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("stop_cmd", int'(want.stop_cmd), int'(i_m_tdata[0]));
                    check_field("start_cmd", int'(want.start_cmd), int'(i_m_tdata[1]));
                    check_field("tone_valid", int'(want.tone_valid), int'(i_m_tdata[2]));
                    check_field("tone_code", int'(want.tone_code), int'(i_m_tdata[4:3]));
                    check_field("error_notice", int'(want.error_notice),
                                int'(i_m_tdata[5]));
                    check_field("tdata pad", 0, int'(i_m_tdata[7:6]));
                end
            end
            if (i_s_tvalid && i_s_tready)
                verdicts_due.push_back(interlock_event(i_s_tuser, i_s_tdata));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    osi_pkg::REG_END_ZONE:    codes.end_zone_code    = i_cfg_wdata;
                    osi_pkg::REG_SECOND_STOP: codes.second_stop_code = i_cfg_wdata;
                    osi_pkg::REG_OBJECT_A:    codes.object_code_a    = i_cfg_wdata;
                    osi_pkg::REG_OBJECT_B:    codes.object_code_b    = i_cfg_wdata;
                    osi_pkg::REG_OBJECT_3D:   codes.object_3d_code   = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        o_pending = verdicts_due.size();
    end

endmodule

// ===== tb/obstacle_stop_interlock_top_tb.sv =====
// Testbench top for the obstacle stop interlock: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module obstacle_stop_interlock_top_tb;

    // Opcodes the block must ignore; the package names only the used ones.
    localparam logic [osi_pkg::OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [osi_pkg::OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RESET_CYCLES    = 12;
    localparam int LAST_PHASE      = 4;
    localparam int ITEMS_PER_PHASE = 245;
    localparam int IDLE_PERCENT    = 22;
    localparam int SETTLE_CYCLES   = 4;   // lets the pipeline empty
    localparam int TAIL_CYCLES     = 8;
    localparam int STALL_LIMIT     = 2000;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_s_tvalid  = 1'b0;
    logic [osi_pkg::IN_DATA_W-1:0]      i_s_tdata   = '0;
    logic [osi_pkg::IN_USER_W-1:0]      i_s_tuser   = '0;
    logic                               i_m_tready  = 1'b0;
    logic                               i_cfg_we    = 1'b0;
    logic [osi_pkg::CFG_IDX_W-1:0]      i_cfg_idx   = '0;
    logic [osi_pkg::CODE_W-1:0]         i_cfg_wdata = '0;
    wire                                o_s_tready;
    wire                                o_m_tvalid;
    wire  [osi_pkg::OUT_DATA_W-1:0]     o_m_tdata;

    int            fail_count;
    int            pending;
    int            events_sent  = 0;
    int            stall_cycles = 0;
    logic          no_idle      = 1'b0;
    logic [7:0]    mode_sent    = 8'd0;
    osi_pkg::t_cfg codes_now    = osi_pkg::CFG_RESET;

    always #2 i_clk = ~i_clk;

    obstacle_stop_interlock_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    obstacle_stop_interlock_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the result side about 22% of cycles; hold it open during burst phases.
    always @(posedge i_clk)
        i_m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Drop the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one event beat and hold it until accepted; before it, idle while each draw
    // falls within the idle odds, so the sender rests in about 22% of its cycles.
    task automatic send_event(
        input logic [osi_pkg::OPCODE_W-1:0] op,
        input logic                         flag,
        input logic [7:0]                   mode,
        input logic [7:0]                   pot,
        input logic [7:0]                   status,
        input logic [7:0]                   zf
    );
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {7'd0, zf, status, pot, mode, flag};
        do @(posedge i_clk); while (!o_s_tready);
        events_sent++;
        if (op == osi_pkg::OP_PACKET)
            mode_sent = mode;
    endtask

    // Hold off the sender until every result is back, then let the pipeline settle.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input osi_pkg::t_reg_idx idx, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic load_codes(input osi_pkg::t_cfg c);
        drain();
        write_reg(osi_pkg::REG_END_ZONE, c.end_zone_code);
        write_reg(osi_pkg::REG_SECOND_STOP, c.second_stop_code);
        write_reg(osi_pkg::REG_OBJECT_A, c.object_code_a);
        write_reg(osi_pkg::REG_OBJECT_B, c.object_code_b);
        write_reg(osi_pkg::REG_OBJECT_3D, c.object_3d_code);
        i_cfg_we  <= 1'b0;
        codes_now  = c;
    endtask

    // Favor values that hit a configured code, zero or all ones.
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return codes_now.end_zone_code;
            2:       return codes_now.second_stop_code;
            3:       return codes_now.object_code_a;
            4:       return codes_now.object_code_b;
            5:       return codes_now.object_3d_code;
            6:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // A waypoint flag that opens a zone: nonzero, neither end nor second stop.
    function automatic logic [7:0] zone_entry_code();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == codes_now.end_zone_code || c == codes_now.second_stop_code);
        return c;
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // One event of any kind. Inside a zone pass keep the drive mode mostly steady,
    // since a mode change returns every flag to its reset value.
    task automatic random_event(input logic steady_mode);
        int         r;
        logic [7:0] mode;
        r    = $urandom_range(0, 99);
        mode = ($urandom_range(0, 99) < (steady_mode ? 90 : 50)) ? mode_sent : rand_byte();
        if (r < 30)
            send_event(osi_pkg::OP_WAYPOINT, rand_bit(), rand_byte(), rand_byte(),
                       rand_byte(), pick_code());
        else if (r < 45)
            send_event(osi_pkg::OP_PACKET, rand_bit(), mode, pick_code(),
                       rand_byte(), rand_byte());
        else if (r < 57)
            send_event(osi_pkg::OP_HEALTH, $urandom_range(0, 99) < 75, rand_byte(),
                       rand_byte(), rand_byte(), rand_byte());
        else if (r < 69)
            send_event(osi_pkg::OP_PRIMARY, rand_bit(), rand_byte(), rand_byte(),
                       rand_byte(), rand_byte());
        else if (r < 81)
            send_event(osi_pkg::OP_STATUS3D, rand_bit(), rand_byte(), rand_byte(),
                       pick_code(), rand_byte());
        else if (r < 93)
            send_event(osi_pkg::OP_SECOND, rand_bit(), rand_byte(), rand_byte(),
                       rand_byte(), rand_byte());
        else
            send_event((r < 97) ? OP_SPARE_LO : OP_SPARE_HI, rand_bit(), rand_byte(),
                       rand_byte(), rand_byte(), rand_byte());
    endtask

    // Well-formed pass through a detection zone: enter, mixed sensor and waypoint
    // traffic with second-stop arming, then leave through the end-of-zone flag.
    task automatic zone_pass();
        int r;
        send_event(osi_pkg::OP_WAYPOINT, rand_bit(), rand_byte(), rand_byte(), rand_byte(),
                   zone_entry_code());
        repeat ($urandom_range(3, 12)) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                send_event(osi_pkg::OP_WAYPOINT, rand_bit(), rand_byte(), rand_byte(),
                           rand_byte(), 8'h00);
            else if (r < 24)
                send_event(osi_pkg::OP_WAYPOINT, rand_bit(), rand_byte(), rand_byte(),
                           rand_byte(), codes_now.second_stop_code);
            else if (r < 34)
                send_event(osi_pkg::OP_SECOND, rand_bit(), rand_byte(), rand_byte(),
                           rand_byte(), rand_byte());
            else
                random_event(1'b1);
        end
        send_event(osi_pkg::OP_WAYPOINT, rand_bit(), rand_byte(), rand_byte(), rand_byte(),
                   codes_now.end_zone_code);
    endtask

    initial begin : stimulus
        osi_pkg::t_cfg codes_next;
        int            quota;
        logic          paused;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset codes: ignored opcodes, quiet events, mode
        // change on a packet, zone entry with stop and restart, unhealthy detector
        // with the one-time notice, second stop point and zone exit.
        send_event(OP_SPARE_LO, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_event(OP_SPARE_HI, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_HEALTH, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_PRIMARY, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_event(osi_pkg::OP_PRIMARY, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_STATUS3D, 1'b0, 8'h00, 8'h00, codes_now.object_3d_code, 8'h00);
        send_event(osi_pkg::OP_STATUS3D, 1'b1, 8'h00, 8'h00, 8'hFF, 8'h00);
        send_event(osi_pkg::OP_SECOND, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_PACKET, 1'b0, 8'h00, codes_now.object_code_a, 8'h00, 8'h00);
        send_event(osi_pkg::OP_PACKET, 1'b1, 8'hFF, codes_now.object_code_b, 8'hFF, 8'hFF);
        send_event(osi_pkg::OP_PACKET, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_WAYPOINT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_WAYPOINT, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h80);
        send_event(osi_pkg::OP_WAYPOINT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_PRIMARY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_WAYPOINT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_HEALTH, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_SECOND, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_WAYPOINT, 1'b0, 8'h00, 8'h00, 8'h00,
                   codes_now.second_stop_code);
        send_event(osi_pkg::OP_WAYPOINT, 1'b0, 8'h00, 8'h00, 8'h00,
                   codes_now.second_stop_code);
        send_event(osi_pkg::OP_HEALTH, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_event(osi_pkg::OP_WAYPOINT, 1'b0, 8'h00, 8'h00, 8'h00, codes_now.end_zone_code);
        send_event(osi_pkg::OP_WAYPOINT, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_event(osi_pkg::OP_PACKET, 1'b0, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_event(osi_pkg::OP_WAYPOINT, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);

        // Random phases: reset codes, all zeros, all ones, random codes in a burst
        // with no idling, and random codes with both 2D codes equal.
        for (int phase = 0; phase <= LAST_PHASE; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: codes_next = '0;
                    2: codes_next = '1;
                    default: begin
                        codes_next.end_zone_code    = rand_byte();
                        codes_next.second_stop_code = rand_byte();
                        codes_next.object_code_a    = rand_byte();
                        codes_next.object_code_b    = rand_byte();
                        codes_next.object_3d_code   = rand_byte();
                        if (phase == LAST_PHASE)
                            codes_next.object_code_b = codes_next.object_code_a;
                    end
                endcase
                load_codes(codes_next);
            end
            no_idle <= (phase == 3);
            quota  = events_sent + ITEMS_PER_PHASE;
            paused = 1'b0;
            while (events_sent < quota) begin
                // In phase 2, hold the sender once mid-phase until the result side is empty.
                if (phase == 2 && !paused && events_sent > quota - ITEMS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) != 0)
                    zone_pass();
                else
                    repeat ($urandom_range(1, 6)) random_event(1'b0);
            end
        end

        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
